// ----- hw/rtl/index_sampler_without_replacement_top_macros.svh -----
// Assertion macros for the index sampler.
`ifndef INDEX_SAMPLER_WITHOUT_REPLACEMENT_TOP_MACROS_SVH
`define INDEX_SAMPLER_WITHOUT_REPLACEMENT_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define ISW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define ISW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/isw_pkg.sv -----
// Shared constants for the index sampler.
package isw_pkg;

    localparam int POP_MAX_DEF   = 1024;
    localparam int RAND_BITS_DEF = 32;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int WORD_W     = 32;
    localparam int OUT_IDX_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_POPULATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE   = 2'd2;

    localparam logic OP_DRAW    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic MODE_RANDOM = 1'b0;
    localparam logic MODE_FLOYD  = 1'b1;

    localparam logic [CFG_W-1:0] POP_RESET    = 11'd1024;
    localparam logic [CFG_W-1:0] SAMPLE_RESET = 11'd1024;

endpackage

// ----- hw/rtl/isw_store.sv -----
// Entry store: one write port, two registered read ports.
module isw_store
    import isw_pkg::*;
#(
    parameter int DEPTH = POP_MAX_DEF,
    parameter int AW    = $clog2(POP_MAX_DEF),
    parameter int DW    = $clog2(POP_MAX_DEF) + 1
)
(
    input  logic          clk,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] entry_mem [DEPTH];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= entry_mem[rd_addr_a];
        rd_b_reg <= entry_mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- hw/rtl/isw_reduce.sv -----
// Range reduction of a random word: (word * span) >> RAND_BITS, registered.
module isw_reduce
    import isw_pkg::*;
#(
    parameter int RAND_BITS = RAND_BITS_DEF,
    parameter int CW        = $clog2(POP_MAX_DEF) + 1,
    parameter int IDXW      = $clog2(POP_MAX_DEF)
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [WORD_W-1:0] word,
    input  logic [CW-1:0]     span,
    output logic [IDXW-1:0]   pick
);

    localparam int WW    = (RAND_BITS < WORD_W) ? RAND_BITS : WORD_W;
    localparam int PW    = WW + CW;
    localparam int EXT_W = RAND_BITS + CW;

    logic [WW-1:0]    word_eff;
    logic [PW-1:0]    prod;
    logic [EXT_W-1:0] prod_ext;
    logic [CW-1:0]    scaled;
    logic [IDXW-1:0]  pick_reg;
    logic [IDXW-1:0]  pick_next;

    assign word_eff = word[WW-1:0];
    assign prod     = PW'(word_eff) * PW'(span);
    assign prod_ext = EXT_W'(prod);
    // span <= POP_MAX, so the scaled value already lies below span
    assign scaled   = prod_ext[RAND_BITS +: CW];

    always_comb
    begin
        pick_next = pick_reg;
        if (load)
        begin
            pick_next = scaled[IDXW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
    end

    assign pick = pick_reg;

endmodule

// ----- hw/rtl/index_sampler_without_replacement_top.sv -----
// A draw goes from idle through a store read (ST_RD) and a write back (ST_WB), where its
// result is registered; input stalls during the single entry store's read and write back.
// An exhausted draw returns its result in the cycle after acceptance.
// Reset and every restart item start a clearing pass over all POP_MAX store entries;
// input is stalled meanwhile, configuration writes are still taken.
// Reset is asynchronous, active low; all but the result index and exhausted flag reset.
`include "index_sampler_without_replacement_top_macros.svh"

module index_sampler_without_replacement_top
    import isw_pkg::*;
#(
    parameter int POP_MAX   = POP_MAX_DEF,
    parameter int RAND_BITS = RAND_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [WORD_W-1:0]    random_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_IDX_W-1:0] sample_index,
    output logic                 exhausted,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDXW   = $clog2(POP_MAX);
    localparam int CW     = IDXW + 1;
    localparam int ENT_W  = IDXW + 1;
    localparam int CMP_W  = (CW > CFG_W) ? CW : CFG_W;
    localparam int OUTX_W = IDXW + OUT_IDX_W;

    localparam int RST_P = (int'(POP_RESET) > POP_MAX) ? POP_MAX : int'(POP_RESET);
    localparam int RST_S = (int'(SAMPLE_RESET) > RST_P) ? RST_P : int'(SAMPLE_RESET);
    localparam logic [CW-1:0]   RST_REM  = CW'(RST_P);
    localparam logic [CW-1:0]   RST_UP   = CW'(RST_P - RST_S);
    localparam logic [IDXW-1:0] CLR_LAST = IDXW'(POP_MAX - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    logic [1:0]           state_reg,  state_next;
    logic [IDXW-1:0]      clr_reg,    clr_next;
    logic [CW-1:0]        rem_reg,    rem_next;     // down counter plus one
    logic [CW-1:0]        up_reg,     up_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] sample_index_reg, sample_index_next;
    logic                 exhausted_reg,    exhausted_next;
    logic [CFG_W-1:0]     pop_size_reg,     pop_size_next;
    logic [CFG_W-1:0]     sample_count_reg, sample_count_next;
    logic                 order_mode_reg,   order_mode_next;

    logic [CMP_W-1:0] pop_ext, eff_wide, samp_ext, samp_wide;
    logic [CW-1:0]    eff_pop, up_init, span, top_w;
    logic [IDXW-1:0]  top_addr, pick, look_pick, look_top, floyd_pick, result_idx;
    logic [ENT_W-1:0] ent_a, ent_b;
    logic [OUTX_W-1:0] result_wide;
    logic             in_accept, out_take, exhaust_now, draw_load;
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    logic [ENT_W-1:0] wr_data;

    // effective population and clamped sample count
    always_comb
    begin
        pop_ext = CMP_W'(pop_size_reg);
        if (pop_ext == '0)
        begin
            eff_wide = CMP_W'(1);
        end
        else if (pop_ext > CMP_W'(POP_MAX))
        begin
            eff_wide = CMP_W'(POP_MAX);
        end
        else
        begin
            eff_wide = pop_ext;
        end
        eff_pop   = eff_wide[CW-1:0];
        samp_ext  = CMP_W'(sample_count_reg);
        samp_wide = (samp_ext > CMP_W'(eff_pop)) ? CMP_W'(eff_pop) : samp_ext;
        up_init   = eff_pop - samp_wide[CW-1:0];
    end

    assign top_w       = rem_reg - CW'(1);
    assign top_addr    = top_w[IDXW-1:0];
    assign span        = (order_mode_reg == MODE_RANDOM) ? rem_reg : (up_reg + CW'(1));
    assign exhaust_now = (order_mode_reg == MODE_RANDOM) ? (rem_reg == '0)
                                                         : (up_reg >= eff_pop);

    assign in_stall  = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign draw_load = in_accept && (op == OP_DRAW);

    isw_reduce #(
        .RAND_BITS (RAND_BITS),
        .CW        (CW),
        .IDXW      (IDXW)
    ) u_reduce (
        .clk  (clk),
        .load (draw_load),
        .word (random_value),
        .span (span),
        .pick (pick)
    );

    isw_store #(
        .DEPTH (POP_MAX),
        .AW    (IDXW),
        .DW    (ENT_W)
    ) u_store (
        .clk       (clk),
        .rd_addr_a (pick),
        .rd_addr_b (top_addr),
        .rd_data_a (ent_a),
        .rd_data_b (ent_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // entry = {valid, value}; an invalid entry maps to its own key
    assign look_pick   = ent_a[IDXW] ? ent_a[IDXW-1:0] : pick;
    assign look_top    = ent_b[IDXW] ? ent_b[IDXW-1:0] : top_addr;
    assign floyd_pick  = ent_a[IDXW] ? up_reg[IDXW-1:0] : pick;
    assign result_idx  = (order_mode_reg == MODE_RANDOM) ? look_pick : floyd_pick;
    assign result_wide = OUTX_W'(result_idx);

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        rem_next          = rem_reg;
        up_next           = up_reg;
        out_valid_next    = out_valid_reg && !out_take;
        sample_index_next = sample_index_reg;
        exhausted_next    = exhausted_reg;
        wr_en             = 1'b0;
        wr_addr           = clr_reg;
        wr_data           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + IDXW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_RESTART)
                    begin
                        rem_next   = eff_pop;
                        up_next    = up_init;
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (exhaust_now)
                    begin
                        out_valid_next    = 1'b1;
                        sample_index_next = '0;
                        exhausted_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                wr_en = 1'b1;
                if (order_mode_reg == MODE_RANDOM)
                begin
                    // swap: pick slot now holds what the top slot held
                    wr_addr  = pick;
                    wr_data  = {1'b1, look_top};
                    rem_next = rem_reg - CW'(1);
                end
                else
                begin
                    wr_addr = floyd_pick;
                    wr_data = {1'b1, floyd_pick};
                    up_next = up_reg + CW'(1);
                end
                out_valid_next    = 1'b1;
                sample_index_next = result_wide[OUT_IDX_W-1:0];
                exhausted_next    = 1'b0;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pop_size_next     = pop_size_reg;
        sample_count_next = sample_count_reg;
        order_mode_next   = order_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POPULATION:   pop_size_next     = cfg_data;
                REG_SAMPLE_COUNT: sample_count_next = cfg_data;
                REG_ORDER_MODE:   order_mode_next   = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            rem_reg          <= RST_REM;
            up_reg           <= RST_UP;
            out_valid_reg    <= 1'b0;
            pop_size_reg     <= POP_RESET;
            sample_count_reg <= SAMPLE_RESET;
            order_mode_reg   <= MODE_RANDOM;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            rem_reg          <= rem_next;
            up_reg           <= up_next;
            out_valid_reg    <= out_valid_next;
            pop_size_reg     <= pop_size_next;
            sample_count_reg <= sample_count_next;
            order_mode_reg   <= order_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_index_reg <= sample_index_next;
        exhausted_reg    <= exhausted_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_index_reg;
    assign exhausted    = exhausted_reg;

    `ISW_ASSERT_NXT(a_draw_reads, in_accept && op == OP_DRAW && !exhaust_now, state_reg == ST_RD, "draw did not start store read")
    `ISW_ASSERT_NXT(a_rd_to_wb, state_reg == ST_RD, state_reg == ST_WB, "read not followed by write back")
    `ISW_ASSERT_IMP(a_wb_slot_free, state_reg == ST_WB, !out_valid_reg, "result slot busy at write back")
    `ISW_ASSERT_IMP(a_wb_not_empty, state_reg == ST_WB && order_mode_reg == MODE_RANDOM, rem_reg != '0, "swap draw with no entries left")

endmodule
